// ===== sv/packbits_style_rle_encoder_defines.svh =====
// assertion macros for the rle encoder back module
`ifndef PACKBITS_STYLE_RLE_ENCODER_DEFINES_SVH
`define PACKBITS_STYLE_RLE_ENCODER_DEFINES_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define PBRLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pbrle_pkg.sv =====
// shared types, constants and helpers of the rle encoder
package pbrle_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int PIX_W       = 32;
  localparam int OUT_OFF_W   = 24;
  localparam int DELTA_W     = 10;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [1:0] SIZE_1B = 2'd0;
  localparam logic [1:0] SIZE_2B = 2'd1;

  localparam logic [7:0] RUN_MAX  = 8'd128;
  localparam logic [7:0] LIT_BASE = 8'd127;
  localparam logic [6:0] LIT_LAST = 7'd127;

  // packet operations handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CL,    // close literal packet of n pixels
    OP_CR,    // close repeat packet of run n
    OP_AL,    // add literal pixel at index n
    OP_ALCL   // add literal pixel at index n, then close with n+1
  } op_t;

  typedef struct packed {
    op_t              a_op;
    logic [7:0]       a_n;
    logic [PIX_W-1:0] a_pix;
    op_t              b_op;   // end-of-stream flush, OP_NONE otherwise
    logic [7:0]       b_n;
    logic [PIX_W-1:0] b_pix;
  } cmd_t;

  function automatic logic [PIX_W-1:0] pix_mask(input logic [1:0] size);
    logic [PIX_W-1:0] m;
    unique case (size)
      SIZE_1B: m = PIX_W'(32'h0000_00ff);
      SIZE_2B: m = PIX_W'(32'h0000_ffff);
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] pix_shift(input logic [1:0] size);
    logic [1:0] s;
    unique case (size)
      SIZE_1B: s = 2'd0;
      SIZE_2B: s = 2'd1;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/pbrle_ifs.sv =====
// channel interfaces: pixel input, buffer write output, configuration write
interface pbrle_pix_if import pbrle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             end_of_stream;

  modport source (output valid, pixel, end_of_stream, input ready);
  modport sink   (input valid, pixel, end_of_stream, output ready);
endinterface

interface pbrle_wr_if import pbrle_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_OFF_W-1:0] write_offset;
  logic [PIX_W-1:0]     write_value;
  logic                 write_kind;
  logic                 last_of_item;
  logic                 stream_done;
  logic [OUT_OFF_W-1:0] total_bytes;
  logic                 overflow;

  modport source (output valid, write_offset, write_value, write_kind, last_of_item,
                  stream_done, total_bytes, overflow, input ready);
  modport sink   (input valid, write_offset, write_value, write_kind, last_of_item,
                  stream_done, total_bytes, overflow, output ready);
endinterface

interface pbrle_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/pbrle_front.sv =====
// front: tracks runs and literals, turns each item into a packet command
module pbrle_front import pbrle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  pbrle_pix_if.sink        pixels,
  input  logic [1:0]       pixel_size,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  logic [PIX_W-1:0] held, held_next;
  logic [7:0]       run, run_next;
  logic [6:0]       lit, lit_next;
  logic             have_first, have_first_next;

  logic [PIX_W-1:0] mask;
  logic [PIX_W-1:0] cur;
  logic [PIX_W-1:0] held_m;
  logic             accept;
  cmd_t             cmd;

  assign mask   = pix_mask(pixel_size);
  assign cur    = pixels.pixel & mask;
  assign held_m = held & mask;
  assign accept = pixels.valid && pixels.ready;

  assign pixels.ready = push_ready;

  always_comb begin
    cmd             = '0;
    cmd.a_op        = OP_NONE;
    cmd.b_op        = OP_NONE;
    held_next       = held;
    run_next        = run;
    lit_next        = lit;
    have_first_next = have_first;

    if (!have_first) begin
      held_next       = cur;
      have_first_next = 1'b1;
    end else if (cur == held_m) begin
      // a pending literal implies a run of one
      if (lit != 7'd0) begin
        cmd.a_op = OP_CL;
        cmd.a_n  = {1'b0, lit};
        lit_next = 7'd0;
        run_next = run + 8'd1;
      end else if (run != RUN_MAX) begin
        run_next = run + 8'd1;
      end else begin
        cmd.a_op  = OP_CR;
        cmd.a_n   = run;
        cmd.a_pix = held_m;
        run_next  = 8'd1;
      end
    end else begin
      if (run > 8'd1) begin
        cmd.a_op  = OP_CR;
        cmd.a_n   = run;
        cmd.a_pix = held_m;
        run_next  = 8'd1;
      end else if (lit == LIT_LAST) begin
        cmd.a_op  = OP_ALCL;
        cmd.a_n   = {1'b0, lit};
        cmd.a_pix = held_m;
        lit_next  = 7'd0;
      end else begin
        cmd.a_op  = OP_AL;
        cmd.a_n   = {1'b0, lit};
        cmd.a_pix = held_m;
        lit_next  = lit + 7'd1;
      end
      held_next = cur;
    end

    if (pixels.end_of_stream) begin
      if (run_next > 8'd1) begin
        cmd.b_op = OP_CR;
        cmd.b_n  = run_next;
      end else begin
        cmd.b_op = OP_ALCL;
        cmd.b_n  = {1'b0, lit_next};
      end
      cmd.b_pix       = cur;
      held_next       = '0;
      run_next        = 8'd1;
      lit_next        = 7'd0;
      have_first_next = 1'b0;
    end
  end

  // items that cause no write never enter the queue
  assign push_valid = accept && (cmd.a_op != OP_NONE || cmd.b_op != OP_NONE);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      run        <= 8'd1;
      lit        <= 7'd0;
      have_first <= 1'b0;
    end else if (accept) begin
      held       <= held_next;
      run        <= run_next;
      lit        <= lit_next;
      have_first <= have_first_next;
    end
  end

endmodule

// ===== sv/pbrle_cmd_queue.sv =====
// short command queue between front and back
module pbrle_cmd_queue import pbrle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ===== sv/pbrle_back.sv =====
// back: expands packet commands into buffer writes and tracks the offset
`include "packbits_style_rle_encoder_defines.svh"

module pbrle_back import pbrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] pixel_size,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       head,
  pbrle_wr_if.source writes
);

  logic [OFFSET_BITS-1:0] ps;
  logic                   ovf;
  logic                   phase;
  logic                   sub;
  logic                   out_valid;

  logic                   eff_b;
  op_t                    op;
  logic [7:0]             n;
  logic [7:0]             n1;
  logic [PIX_W-1:0]       pix;
  logic [1:0]             sh;
  logic [DELTA_W-1:0]     n_sh;
  logic [DELTA_W-1:0]     n1_sh;
  logic [DELTA_W-1:0]     one_sh;

  logic                   is_pix;
  logic [7:0]             opc;
  logic [DELTA_W-1:0]     delta;
  logic                   adv_en;
  logic [DELTA_W-1:0]     adv;

  logic                   two_part;
  logic                   op_done;
  logic                   cmd_last;
  logic                   eos;
  logic                   step;
  logic                   stream_end;

  logic [OFFSET_BITS:0]   off_sum;
  logic [OFFSET_BITS:0]   adv_sum;
  logic [OFFSET_BITS-1:0] off_sat;
  logic [OFFSET_BITS-1:0] ps_next;
  logic                   ovf_w;
  logic                   ovf_next;

  assign eff_b  = phase || (head.a_op == OP_NONE);
  assign op     = eff_b ? head.b_op : head.a_op;
  assign n      = eff_b ? head.b_n : head.a_n;
  assign pix    = eff_b ? head.b_pix : head.a_pix;
  assign n1     = n + 8'd1;
  assign sh     = pix_shift(pixel_size);
  assign n_sh   = DELTA_W'(n) << sh;
  assign n1_sh  = DELTA_W'(n1) << sh;
  assign one_sh = DELTA_W'(1) << sh;

  always_comb begin
    is_pix = 1'b0;
    opc    = 8'd0;
    delta  = '0;
    adv_en = 1'b0;
    adv    = '0;
    unique case (op)
      OP_CL: begin
        opc    = LIT_BASE + n;
        adv_en = 1'b1;
        adv    = DELTA_W'(1) + n_sh;
      end
      OP_CR: begin
        if (!sub) begin
          opc = n - 8'd1;
        end else begin
          is_pix = 1'b1;
          delta  = DELTA_W'(1);
          adv_en = 1'b1;
          adv    = DELTA_W'(1) + one_sh;
        end
      end
      OP_AL: begin
        is_pix = 1'b1;
        delta  = DELTA_W'(1) + n_sh;
      end
      OP_ALCL: begin
        if (!sub) begin
          is_pix = 1'b1;
          delta  = DELTA_W'(1) + n_sh;
        end else begin
          opc    = LIT_BASE + n1;
          adv_en = 1'b1;
          adv    = DELTA_W'(1) + n1_sh;
        end
      end
      default: begin
        is_pix = 1'b0;
      end
    endcase
  end

  assign two_part   = (op == OP_CR) || (op == OP_ALCL);
  assign op_done    = !two_part || sub;
  assign cmd_last   = op_done && (eff_b || head.b_op == OP_NONE);
  assign eos        = head.b_op != OP_NONE;
  assign step       = pop_valid && (!out_valid || writes.ready);
  assign pop_ready  = step && cmd_last;
  assign stream_end = step && cmd_last && eos;

  // ps never exceeds the limit, so the carry bit marks an overflow
  assign off_sum  = {1'b0, ps} + (OFFSET_BITS+1)'(delta);
  assign adv_sum  = {1'b0, ps} + (OFFSET_BITS+1)'(adv);
  assign off_sat  = off_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : off_sum[OFFSET_BITS-1:0];
  assign ovf_w    = ovf || off_sum[OFFSET_BITS];
  assign ps_next  = !adv_en ? ps :
                    (adv_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : adv_sum[OFFSET_BITS-1:0]);
  assign ovf_next = ovf_w || (adv_en && adv_sum[OFFSET_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ps        <= '0;
      ovf       <= 1'b0;
      phase     <= 1'b0;
      sub       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (writes.ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (cmd_last) begin
          phase <= 1'b0;
          sub   <= 1'b0;
        end else if (op_done) begin
          phase <= 1'b1;
          sub   <= 1'b0;
        end else begin
          sub <= 1'b1;
        end
        if (stream_end) begin
          ps  <= '0;
          ovf <= 1'b0;
        end else begin
          ps  <= ps_next;
          ovf <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      writes.write_offset <= OUT_OFF_W'(off_sat);
      writes.write_value  <= is_pix ? pix : PIX_W'(opc);
      writes.write_kind   <= is_pix;
      writes.last_of_item <= cmd_last;
      writes.stream_done  <= cmd_last && eos;
      writes.total_bytes  <= (cmd_last && eos) ? OUT_OFF_W'(ps_next) : '0;
      writes.overflow     <= (cmd_last && eos) ? ovf_next : ovf_w;
    end
  end

  assign writes.valid = out_valid;

  `PBRLE_ASSERT_NEXT(a_end_clears, stream_end, ps == '0 && !ovf, "stream state not cleared")
  `PBRLE_ASSERT_NEXT(a_ovf_sticky, ovf && !stream_end, ovf, "overflow flag dropped mid-stream")
  `PBRLE_ASSERT_IMPL(a_sub_two_part, sub, pop_valid && two_part, "second write of one-write op")
  `PBRLE_ASSERT_IMPL(a_phase_flush, phase, pop_valid && head.b_op != OP_NONE, "flush without op")

endmodule

// ===== sv/packbits_style_rle_encoder.sv =====
// an item's first write is registered in the queue, then in the back's output register;
// throughput: one pixel per cycle while the 4-entry queue has room; the back makes one
// write per cycle while writes.ready holds, 0 to 4 per pixel, so writes set the rate
// reset (rst, synchronous): pixel size back to one byte, stream state, offset, queue
// and output valid cleared; the next pixel starts a new image at offset 0
module packbits_style_rle_encoder import pbrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pbrle_cfg_if.sink  cfg,
  pbrle_pix_if.sink  pixels,
  pbrle_wr_if.source writes
);

  logic [1:0] pixel_size;
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_size <= SIZE_1B;
    end else if (cfg.valid && cfg.ready) begin
      pixel_size <= cfg.data;
    end
  end

  pbrle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .pixel_size (pixel_size),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  pbrle_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  pbrle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pixel_size (pixel_size),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .head       (pop_cmd),
    .writes     (writes)
  );

endmodule
